// File: rtl/tii_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tii_pkg;

  // Fixed field widths
  localparam int LETTER_W = 5;
  localparam int DOC_IDX_W = 6;
  localparam int MASK_W = 64;
  localparam int STATUS_W = 2;

  // Parameter defaults
  localparam int NODE_COUNT_DEF = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int DOC_COUNT_DEF = 64;

  // Commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_POOL_FULL = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // clearing pass: write zero at the sweep address
    logic accept;  // latch input beat, issue link read
    logic step;    // resolve link, issue mask read
    logic finish;  // update mask, load result register, rewind walk
  } tii_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic word_end;
    logic out_busy;
  } tii_stat_t;

endpackage

`default_nettype wire

// File: rtl/tii_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tii_ctrl
  import tii_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tii_stat_t stat,
  output tii_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_STEP   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_nxt = stat.word_end ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/tii_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tii_datapath
  import tii_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int DOC_COUNT = DOC_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tii_cmd_t             cmd,
  output tii_stat_t                 stat,
  input  wire logic                 in_cmd,
  input  wire logic [LETTER_W-1:0]  in_letter,
  input  wire logic                 in_has_letter,
  input  wire logic                 in_word_end,
  input  wire logic [DOC_IDX_W-1:0] in_doc_index,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [MASK_W-1:0]         out_doc_mask,
  output logic [STATUS_W-1:0]       out_status
);

  localparam int NODE_AW = $clog2(NODE_COUNT);
  localparam int NF_W = $clog2(NODE_COUNT + 1);
  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int LINK_AW = $clog2(LINK_DEPTH);
  localparam int LCMP_W = LETTER_W + 4;
  localparam logic [MASK_W-1:0] DOC_LIMIT =
    (DOC_COUNT >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << DOC_COUNT) - MASK_W'(1));

  logic [NODE_AW-1:0] link_mem [LINK_DEPTH];
  logic [MASK_W-1:0]  mask_mem [NODE_COUNT];

  logic [NODE_AW-1:0]   link_q_r;
  logic [MASK_W-1:0]    mask_q_r;
  logic [LINK_AW-1:0]   clr_cnt_r;
  logic [NODE_AW-1:0]   walk_r, walk_nxt;
  logic                 missed_r, missed_nxt;
  logic                 over_r, over_nxt;
  logic [NF_W-1:0]      next_free_r, next_free_nxt;

  // latched item
  logic                 cmd_r;
  logic [LETTER_W-1:0]  letter_r;
  logic                 has_letter_r;
  logic                 word_end_r;
  logic [DOC_IDX_W-1:0] doc_r;
  logic [LINK_AW-1:0]   slot_r;

  logic [LINK_AW-1:0]   slot_in;
  logic                 in_range_in;
  logic                 in_range;
  logic                 link_we;
  logic [LINK_AW-1:0]   link_waddr;
  logic [NODE_AW-1:0]   link_wdata;
  logic                 mask_we;
  logic [NODE_AW-1:0]   mask_waddr;
  logic [MASK_W-1:0]    mask_wdata;
  logic [MASK_W-1:0]    mask_upd;
  logic                 fail;
  logic                 doc_ok;

  logic                 out_valid_r;
  logic [MASK_W-1:0]    out_mask_r;
  status_t              out_status_r;

  assign in_range_in = {4'd0, in_letter} < LCMP_W'(ALPHABET_SIZE);
  assign in_range = {4'd0, letter_r} < LCMP_W'(ALPHABET_SIZE);
  assign slot_in = LINK_AW'(walk_r) * LINK_AW'(ALPHABET_SIZE)
                 + (in_range_in ? LINK_AW'(in_letter) : '0);

  // walk update on a letter beat; also the clearing-pass link writes and the rewind on finish
  always_comb begin
    walk_nxt = walk_r;
    missed_nxt = missed_r;
    over_nxt = over_r;
    next_free_nxt = next_free_r;
    link_we = 1'b0;
    link_waddr = slot_r;
    link_wdata = next_free_r[NODE_AW-1:0];
    if (cmd.clear) begin
      link_we = 1'b1;
      link_waddr = clr_cnt_r;
      link_wdata = '0;
    end else if (cmd.step && has_letter_r && !missed_r && !over_r) begin
      if (!in_range) begin
        if (cmd_r == CMD_QUERY) missed_nxt = 1'b1;
        else over_nxt = 1'b1;
      end else if (link_q_r == '0) begin
        if (cmd_r == CMD_QUERY) begin
          missed_nxt = 1'b1;
        end else if (next_free_r >= NF_W'(NODE_COUNT)) begin
          over_nxt = 1'b1;
        end else begin
          link_we = 1'b1;
          walk_nxt = next_free_r[NODE_AW-1:0];
          next_free_nxt = next_free_r + NF_W'(1);
        end
      end else begin
        walk_nxt = link_q_r;
      end
    end else if (cmd.finish) begin
      walk_nxt = '0;
      missed_nxt = 1'b0;
      over_nxt = 1'b0;
    end
  end

  // word end: mask update and result
  assign fail = missed_r | over_r;
  assign doc_ok = {1'b0, doc_r} < (DOC_IDX_W + 1)'(DOC_COUNT);
  assign mask_upd = mask_q_r | (doc_ok ? (MASK_W'(1) << doc_r) : '0);

  always_comb begin
    mask_we = 1'b0;
    mask_waddr = walk_r;
    mask_wdata = mask_upd;
    if (cmd.clear) begin
      mask_we = clr_cnt_r < LINK_AW'(NODE_COUNT);
      mask_waddr = clr_cnt_r[NODE_AW-1:0];
      mask_wdata = '0;
    end else if (cmd.finish && !fail && cmd_r == CMD_INSERT) begin
      mask_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (cmd.accept) link_q_r <= link_mem[slot_in];
  end

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_waddr] <= mask_wdata;
    if (cmd.step) mask_q_r <= mask_mem[walk_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      letter_r <= in_letter;
      has_letter_r <= in_has_letter;
      word_end_r <= in_word_end;
      doc_r <= in_doc_index;
      slot_r <= slot_in;
    end
    if (cmd.finish) begin
      if (fail) begin
        out_mask_r <= '0;
        out_status_r <= (cmd_r == CMD_QUERY) ? ST_NOT_FOUND : ST_POOL_FULL;
      end else begin
        out_mask_r <= ((cmd_r == CMD_QUERY) ? mask_q_r : mask_upd) & DOC_LIMIT;
        out_status_r <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      walk_r <= '0;
      missed_r <= 1'b0;
      over_r <= 1'b0;
      next_free_r <= NF_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + LINK_AW'(1);
      walk_r <= walk_nxt;
      missed_r <= missed_nxt;
      over_r <= over_nxt;
      next_free_r <= next_free_nxt;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign stat.clear_done = clr_cnt_r == LINK_AW'(LINK_DEPTH - 1);
  assign stat.word_end = word_end_r;
  assign stat.out_busy = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign out_doc_mask = out_mask_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// File: rtl/trie_inverted_index_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    cmd, letter, has_letter, word_end, doc_index
// out_      output     out_valid / out_ready  doc_mask, status (one beat per word end)
//
// A letter beat goes through accept, which issues the child link read, and
// step, which resolves the link (follow or allocate); a word-end beat adds
// finish for the node mask read-modify-write. After reset a clearing pass
// over all NODE_COUNT*ALPHABET_SIZE link entries (26624 by default) zeroes
// the link and mask memories; in_ready stays low meanwhile. A word end
// stalls while a previous result beat still waits on out_ready.

module trie_inverted_index_core
  import tii_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int DOC_COUNT = DOC_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_cmd,
  input  wire logic [LETTER_W-1:0]  in_letter,
  input  wire logic                 in_has_letter,
  input  wire logic                 in_word_end,
  input  wire logic [DOC_IDX_W-1:0] in_doc_index,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [MASK_W-1:0]         out_doc_mask,
  output logic [STATUS_W-1:0]       out_status
);

  tii_cmd_t  cmd;
  tii_stat_t stat;

  // Sequencer: clear pass, then accept / step per beat and finish per word end
  tii_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Link and mask memories, walk state, node allocator, result register
  tii_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .DOC_COUNT     (DOC_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_letter     (in_letter),
    .in_has_letter (in_has_letter),
    .in_word_end   (in_word_end),
    .in_doc_index  (in_doc_index),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_doc_mask  (out_doc_mask),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tii_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int ALPHA = ALPHABET_SIZE_DEF;
  localparam int DOCS = DOC_COUNT_DEF;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    status_t status;
  } word_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_INSERT;
  logic [LETTER_W-1:0] in_letter = '0;
  logic in_has_letter = 1'b0;
  logic in_word_end = 1'b0;
  logic [DOC_IDX_W-1:0] in_doc_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MASK_W-1:0] out_doc_mask;
  logic [STATUS_W-1:0] out_status;

  // Idle and stall odds in percent, set per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int beats_sent = 0;

  // Shadow trie: child links, per-node document masks and the walk position.
  int trie_link [NODES*ALPHA];
  bit [MASK_W-1:0] doc_masks [NODES];
  int next_node = 1;
  int walk_at = 0;
  bit walk_miss = 1'b0;
  bit walk_full = 1'b0;
  word_result_t pending_results[$];

  trie_inverted_index_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_letter(in_letter),
    .in_has_letter(in_has_letter),
    .in_word_end(in_word_end),
    .in_doc_index(in_doc_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_doc_mask(out_doc_mask),
    .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow trie by one accepted beat; queue the word result
  // when the beat closes a word.
  function automatic void walk_trie(logic cmd, logic [LETTER_W-1:0] letter, logic has,
                                    logic fin, logic [DOC_IDX_W-1:0] doc);
    int slot;
    int link;
    word_result_t res;
    if (has && !walk_miss && !walk_full) begin
      if (letter >= ALPHA) begin
        // Letter outside the alphabet fails the word either way.
        if (cmd == CMD_QUERY) walk_miss = 1'b1;
        else walk_full = 1'b1;
      end else begin
        slot = walk_at * ALPHA + letter;
        link = trie_link[slot];
        if (link == 0) begin
          if (cmd == CMD_QUERY) begin
            walk_miss = 1'b1;
          end else if (next_node >= NODES) begin
            walk_full = 1'b1;
          end else begin
            link = next_node;
            trie_link[slot] = link;
            next_node++;
          end
        end
        if (!walk_miss && !walk_full) walk_at = link;
      end
    end
    if (fin) begin
      res.mask = '0;
      res.status = ST_OK;
      if (walk_miss || walk_full) begin
        // The closing beat's command picks the error code.
        res.status = (cmd == CMD_QUERY) ? ST_NOT_FOUND : ST_POOL_FULL;
      end else begin
        if (cmd == CMD_INSERT && doc < DOCS) doc_masks[walk_at][doc] = 1'b1;
        res.mask = doc_masks[walk_at];
      end
      pending_results.push_back(res);
      walk_at = 0;
      walk_miss = 1'b0;
      walk_full = 1'b0;
    end
  endfunction

  // Present one beat, hold it until accepted, then advance the shadow trie.
  task automatic send_beat(logic cmd, logic [LETTER_W-1:0] letter, logic has, logic fin,
                           logic [DOC_IDX_W-1:0] doc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_letter <= letter;
    in_has_letter <= has;
    in_word_end <= fin;
    in_doc_index <= doc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    walk_trie(cmd, letter, has, fin, doc);
    if (has || fin) beats_sent++;
  endtask

  // Send a word spelled in lowercase text; an empty string is the empty word.
  task automatic send_text(logic cmd, string text, logic [DOC_IDX_W-1:0] doc);
    int i;
    if (text.len() == 0) begin
      send_beat(cmd, '0, 1'b0, 1'b1, doc);
    end else begin
      for (i = 0; i < text.len(); i++)
        send_beat(cmd, LETTER_W'(text[i] - 8'd97), 1'b1, i == text.len() - 1, doc);
    end
  endtask

  // Drop valid and hold until every queued word result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall out_ready at the phase's odds.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result beat with the oldest queued expectation.
  always @(posedge clk) begin
    word_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat mask=%h status=%0d", $time, out_doc_mask,
                 out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_doc_mask !== want.mask) begin
          $display("%0t: doc_mask expected %h actual %h", $time, want.mask, out_doc_mask);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

  // Empty words name the root; letterless beats that do not end a word do nothing.
  task automatic test_empty_words();
    send_text(CMD_QUERY, "", 6'd0);
    send_beat(CMD_INSERT, 5'd31, 1'b0, 1'b0, 6'd63);
    send_text(CMD_INSERT, "", 6'd63);
    send_beat(CMD_QUERY, 5'd21, 1'b0, 1'b0, 6'd42);
    send_text(CMD_QUERY, "", 6'd21);
  endtask

  // Insert at both ends of the document range, query hits, prefixes and misses.
  task automatic test_insert_query();
    send_text(CMD_INSERT, "ab", 6'd0);
    send_text(CMD_INSERT, "ab", 6'd63);
    send_text(CMD_QUERY, "ab", 6'd0);
    send_text(CMD_QUERY, "a", 6'd0);
    send_text(CMD_QUERY, "abc", 6'd0);
    send_text(CMD_INSERT, "z", 6'd42);
    send_text(CMD_QUERY, "z", 6'd21);
  endtask

  // Out-of-alphabet letters and words whose beats mix commands.
  task automatic test_bad_words();
    send_beat(CMD_INSERT, 5'd31, 1'b1, 1'b1, 6'd1);
    send_beat(CMD_QUERY, 5'd26, 1'b1, 1'b1, 6'd1);
    send_beat(CMD_INSERT, 5'd2, 1'b1, 1'b0, 6'd0);
    send_beat(CMD_QUERY, 5'd0, 1'b1, 1'b1, 6'd0);
    send_beat(CMD_QUERY, 5'd24, 1'b1, 1'b0, 6'd0);
    send_beat(CMD_INSERT, 5'd0, 1'b1, 1'b1, 6'd7);
    send_beat(CMD_QUERY, 5'd0, 1'b1, 1'b0, 6'd0);
    send_beat(CMD_INSERT, 5'd1, 1'b0, 1'b1, 6'd9);
  endtask

  // One random word: mostly letters a..d so queries hit, with a few wide or
  // out-of-range letters, flipped commands, stray letterless beats and
  // words closed by a letterless beat.
  task automatic send_random_word();
    logic cmd;
    logic bit_cmd;
    logic split_end;
    logic [LETTER_W-1:0] ltr;
    logic [DOC_IDX_W-1:0] doc;
    int len;
    int pick;
    int i;
    cmd = 1'($urandom_range(0, 1));
    len = $urandom_range(0, 5);
    doc = DOC_IDX_W'($urandom_range(0, 63));
    if (len == 0) begin
      send_beat(cmd, LETTER_W'($urandom_range(0, 31)), 1'b0, 1'b1, doc);
    end else begin
      split_end = ($urandom_range(0, 19) == 0);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)), 1'b0, 1'b0,
                    DOC_IDX_W'($urandom_range(0, 63)));
        pick = $urandom_range(0, 99);
        if (pick < 75) ltr = LETTER_W'($urandom_range(0, 3));
        else if (pick < 95) ltr = LETTER_W'($urandom_range(0, 25));
        else ltr = LETTER_W'($urandom_range(26, 31));
        bit_cmd = ($urandom_range(0, 19) == 0) ? ~cmd : cmd;
        if (i == len - 1 && !split_end) bit_cmd = cmd;
        send_beat(bit_cmd, ltr, 1'b1, (i == len - 1) && !split_end, doc);
      end
      if (split_end) send_beat(cmd, LETTER_W'($urandom_range(0, 31)), 1'b0, 1'b1, doc);
    end
  endtask

  // Random words under one idle/stall setting, then wait out every result.
  task automatic test_random_words(int count, int idle_pct, int stall_pct);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) send_random_word();
    drain_results();
  endtask

  // Grow one chain of 'z' past the pool size, then probe around the full pool.
  task automatic test_pool_exhaustion();
    int len;
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    len = NODES - next_node + 30;
    for (i = 0; i < len; i++)
      send_beat(CMD_INSERT, 5'd25, 1'b1, i == len - 1, DOC_IDX_W'($urandom_range(0, 63)));
    // Nodes built before the overflow stay reachable.
    send_text(CMD_QUERY, "zzzzzzzzzz", 6'd0);
    send_text(CMD_INSERT, "zzzzzzzzzz", 6'd17);
    send_text(CMD_INSERT, "yx", 6'd3);
    send_text(CMD_QUERY, "yx", 6'd3);
    send_text(CMD_INSERT, "ab", 6'd5);
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_words();
    test_insert_query();
    test_bad_words();
    // Hold off until every directed result is back.
    drain_results();
    test_random_words(50, 0, 0);
    test_random_words(50, 72, 0);
    test_random_words(50, 0, 72);
    test_random_words(50, 11, 11);
    test_pool_exhaustion();
    test_random_words(50, 11, 11);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
